@@ hdl/keyed_byte_keystream_xor_macros.svh @@
// Assertion macros shared by the keystream block.
`ifndef KEYED_BYTE_KEYSTREAM_XOR_MACROS_SVH
`define KEYED_BYTE_KEYSTREAM_XOR_MACROS_SVH
`ifndef SYNTHESIS
`define KBKX_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("kbkx assertion failed");
`define KBKX_ASSERT_NEXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) \
		else $error("kbkx assertion failed");
`else
`define KBKX_ASSERT(name, clk, rst_n, prop)
`define KBKX_ASSERT_NEXT(name, clk, rst_n, pre, post)
`endif
`endif

@@ hdl/kbkx_pkg.sv @@
package kbkx_pkg;

	localparam int KEY_MAX = 32;
	localparam int SEED_W = 16;
	localparam int MIX_W = 24;
	localparam int BYTE_W = 8;
	localparam int DIV_STEPS = SEED_W;
	localparam int CNT_W = $clog2(DIV_STEPS);

	localparam logic [SEED_W-1:0] SEED_INIT = 16'd358;
	localparam logic [MIX_W-1:0] MIX_ONE_INIT = 24'd15;
	localparam logic [MIX_W-1:0] MIX_TWO_INIT = 24'd17;
	localparam logic [SEED_W:0] ADD_ONE = 17'd5;
	localparam logic [SEED_W:0] ADD_TWO = 17'd7;

	localparam logic ACT_KEY = 1'b0;
	localparam logic ACT_DATA = 1'b1;

	typedef struct packed {
		logic action;
		logic [BYTE_W-1:0] byte_in;
		logic key_last;
	} in_t;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_out;
		logic no_key;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_FOLD,
		ST_SUM,
		ST_MIX,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic take_item;
		logic take_key;
		logic take_pass;
		logic div_step;
		logic key_fin;
		logic sum;
		logic mix;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic armed;
	} sts_t;

endpackage

@@ hdl/keyed_byte_keystream_xor.sv @@
// Byte stream cipher: send key bytes (action 0) with key_last on the final one, then data
// bytes (action 1); each data byte returns one result beat XORed with the keystream, and a data
// byte sent before a key is armed comes back unchanged with no_key set. Key bytes return
// nothing. A key byte occupies the block while the bit-serial remainder unit folds the byte into
// the seed; a keyed data byte passes through key memory read, seed add, multiply-add update and
// output load, and a pass-through byte goes straight to output load. A new beat is taken
// while a finished result waits in the output register. Up to KEY_MAX key bytes are kept; later
// ones are ignored, and a key byte after an armed key starts a new key.
module keyed_byte_keystream_xor #(
	parameter int KEY_MAX = kbkx_pkg::KEY_MAX
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  kbkx_pkg::in_t   item,
	output logic            result_valid,
	input  logic            result_stall,
	output kbkx_pkg::out_t  result
);

	kbkx_pkg::cmd_t cmd;
	kbkx_pkg::sts_t sts;

	kbkx_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_action  (item.action),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	kbkx_dp #(
		.KEY_MAX (KEY_MAX)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

endmodule

@@ hdl/kbkx_ctrl.sv @@
`include "keyed_byte_keystream_xor_macros.svh"

module kbkx_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  logic            item_action,
	output logic            item_stall,
	output logic            result_valid,
	input  logic            result_stall,
	input  kbkx_pkg::sts_t  sts,
	output kbkx_pkg::cmd_t  cmd
);

	localparam logic [kbkx_pkg::CNT_W-1:0] DivLast = kbkx_pkg::CNT_W'(kbkx_pkg::DIV_STEPS - 1);

	kbkx_pkg::state_t state_q, state_d;
	logic [kbkx_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic result_valid_q, result_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kbkx_pkg::ST_IDLE;
			cnt_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			result_valid_q <= result_valid_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		item_stall = 1'b1;
		unique case (state_q)
			kbkx_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.take_item = 1'b1;
					if (item_action == kbkx_pkg::ACT_KEY) begin
						cmd.take_key = 1'b1;
						cnt_d = '0;
						state_d = kbkx_pkg::ST_DIV;
					end else if (!sts.armed) begin
						cmd.take_pass = 1'b1;
						state_d = kbkx_pkg::ST_EMIT;
					end else begin
						state_d = kbkx_pkg::ST_SUM;
					end
				end
			end
			kbkx_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DivLast) begin
					state_d = kbkx_pkg::ST_FOLD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			kbkx_pkg::ST_FOLD: begin
				cmd.key_fin = 1'b1;
				state_d = kbkx_pkg::ST_IDLE;
			end
			kbkx_pkg::ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = kbkx_pkg::ST_MIX;
			end
			kbkx_pkg::ST_MIX: begin
				cmd.mix = 1'b1;
				state_d = kbkx_pkg::ST_EMIT;
			end
			kbkx_pkg::ST_EMIT: begin
				if (!result_valid_q || !result_stall) begin
					cmd.out_load = 1'b1;
					state_d = kbkx_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = kbkx_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		if (cmd.out_load) begin
			result_valid_d = 1'b1;
		end else if (!result_stall) begin
			result_valid_d = 1'b0;
		end else begin
			result_valid_d = result_valid_q;
		end
	end

	assign result_valid = result_valid_q;

	`KBKX_ASSERT_NEXT(a_div_to_fold, clk, arst_n, (state_q == kbkx_pkg::ST_DIV) && (cnt_q == DivLast), state_q == kbkx_pkg::ST_FOLD)
	`KBKX_ASSERT(a_no_overwrite, clk, arst_n, !(cmd.out_load && result_valid_q && result_stall))
	`KBKX_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, (state_q == kbkx_pkg::ST_IDLE) && item_valid, state_q != kbkx_pkg::ST_IDLE)

endmodule

@@ hdl/kbkx_dp.sv @@
`include "keyed_byte_keystream_xor_macros.svh"

module kbkx_dp #(
	parameter int KEY_MAX = kbkx_pkg::KEY_MAX
) (
	input  logic            clk,
	input  logic            arst_n,
	input  kbkx_pkg::in_t   item,
	input  kbkx_pkg::cmd_t  cmd,
	output kbkx_pkg::sts_t  sts,
	output kbkx_pkg::out_t  result
);

	localparam int LenW = $clog2(KEY_MAX + 1);
	localparam int IdxW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int SW = kbkx_pkg::SEED_W;
	localparam int MW = kbkx_pkg::MIX_W;
	localparam int BW = kbkx_pkg::BYTE_W;

	logic [BW-1:0] key_mem [KEY_MAX];
	logic [BW-1:0] rd_q;

	logic [LenW-1:0] len_q;
	logic armed_q;
	logic [IdxW-1:0] idx_q;
	logic [SW-1:0] seed_q;
	logic [MW-1:0] mix_one_q, mix_two_q;

	logic [BW-1:0] byte_q;
	logic last_q;
	logic [SW-1:0] dvd_q;
	logic [BW:0] dsr_q;
	logic [BW:0] rem_q;
	logic [SW-1:0] sum_q;
	kbkx_pkg::out_t res_q, result_q;

	logic room;
	logic [BW+1:0] trial;
	logic [SW:0] add_one, add_two;
	logic [MW:0] prod_one, prod_two;
	logic [MW-1:0] mix_one_n, mix_two_n;
	logic [LenW-1:0] idx_inc;
	logic [IdxW-1:0] idx_n;

	assign room = len_q < LenW'(KEY_MAX);
	assign trial = {rem_q, dvd_q[SW-1]};

	assign add_one = {1'b0, sum_q} + kbkx_pkg::ADD_ONE;
	assign add_two = {1'b0, sum_q} + kbkx_pkg::ADD_TWO;
	assign prod_one = (MW+1)'(add_one) * (MW+1)'(mix_one_q[BW-1:0]);
	assign prod_two = (MW+1)'(add_two) * (MW+1)'(mix_two_q[BW-1:0]);
	assign mix_one_n = MW'(prod_one + (MW+1)'(mix_one_q[MW-1:BW]));
	assign mix_two_n = MW'(prod_two + (MW+1)'(mix_two_q[MW-1:BW]));

	assign idx_inc = LenW'(idx_q) + LenW'(1);
	assign idx_n = (idx_inc >= len_q) ? '0 : IdxW'(idx_inc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			armed_q <= 1'b0;
			idx_q <= '0;
			seed_q <= kbkx_pkg::SEED_INIT;
			mix_one_q <= kbkx_pkg::MIX_ONE_INIT;
			mix_two_q <= kbkx_pkg::MIX_TWO_INIT;
		end else begin
			if (cmd.take_key && armed_q) begin
				armed_q <= 1'b0;
				len_q <= '0;
				seed_q <= kbkx_pkg::SEED_INIT;
			end
			if (cmd.key_fin) begin
				if (room) begin
					len_q <= len_q + 1'b1;
					seed_q <= seed_q + SW'(rem_q);
				end
				if (last_q) begin
					armed_q <= 1'b1;
					mix_one_q <= kbkx_pkg::MIX_ONE_INIT;
					mix_two_q <= kbkx_pkg::MIX_TWO_INIT;
					idx_q <= '0;
				end
			end
			if (cmd.mix) begin
				mix_one_q <= mix_one_n;
				mix_two_q <= mix_two_n;
				seed_q <= SW'(mix_two_n[BW-1:0]);
				idx_q <= idx_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.key_fin && room) begin
			key_mem[len_q[IdxW-1:0]] <= byte_q;
		end
		rd_q <= key_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			byte_q <= item.byte_in;
			last_q <= item.key_last;
		end
		if (cmd.take_key) begin
			dvd_q <= armed_q ? kbkx_pkg::SEED_INIT : seed_q;
			dsr_q <= {1'b0, item.byte_in} + 1'b1;
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			dvd_q <= {dvd_q[SW-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= (BW+1)'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[BW:0];
			end
		end
		if (cmd.sum) begin
			sum_q <= seed_q + SW'(rd_q);
		end
		if (cmd.take_pass) begin
			res_q.byte_out <= item.byte_in;
			res_q.no_key <= 1'b1;
		end
		if (cmd.mix) begin
			res_q.byte_out <= byte_q ^ mix_two_n[BW-1:0];
			res_q.no_key <= 1'b0;
		end
		if (cmd.out_load) begin
			result_q <= res_q;
		end
	end

	assign sts.armed = armed_q && (len_q != '0);
	assign result = result_q;

	`KBKX_ASSERT(a_idx_in_key, clk, arst_n, !armed_q || (LenW'(idx_q) < len_q))

endmodule

@@ dv/tb.sv @@
module tb;

	localparam int QUIET_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 1200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	kbkx_pkg::in_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	kbkx_pkg::out_t result;

	keyed_byte_keystream_xor DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	logic [7:0] key_mem [kbkx_pkg::KEY_MAX];
	int key_cnt = 0;
	int key_pos = 0;
	logic armed = 1'b0;
	logic [15:0] seed = kbkx_pkg::SEED_INIT;
	logic [23:0] mix_a = kbkx_pkg::MIX_ONE_INIT;
	logic [23:0] mix_b = kbkx_pkg::MIX_TWO_INIT;

	kbkx_pkg::out_t cipher_bytes [$];
	kbkx_pkg::out_t want;
	logic jitter = 1'b1;
	int n_key = 0;
	int n_data = 0;
	int n_plain = 0;
	int n_counted = 0;
	int n_checked = 0;
	int n_errors = 0;
	int quiet = 0;

	always #5 clk = ~clk;

	task automatic report(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		n_errors++;
	endtask

	function automatic void encrypt_beat(input kbkx_pkg::in_t it);
		int unsigned s;
		kbkx_pkg::out_t r;
		if (it.action == kbkx_pkg::ACT_KEY) begin
			n_key++;
			if (armed) begin
				armed = 1'b0;
				key_cnt = 0;
				seed = kbkx_pkg::SEED_INIT;
			end
			if (key_cnt < kbkx_pkg::KEY_MAX) begin
				key_mem[key_cnt] = it.byte_in;
				key_cnt++;
				n_counted++;
				s = seed + seed % (it.byte_in + 1);
				seed = s[15:0];
			end
			if (it.key_last) begin
				armed = 1'b1;
				mix_a = kbkx_pkg::MIX_ONE_INIT;
				mix_b = kbkx_pkg::MIX_TWO_INIT;
				key_pos = 0;
			end
			return;
		end
		n_data++;
		n_counted++;
		if (!armed || key_cnt == 0) begin
			n_plain++;
			r.byte_out = it.byte_in;
			r.no_key = 1'b1;
		end else begin
			if (key_pos >= key_cnt)
				key_pos = 0;
			s = seed + key_mem[key_pos];
			seed = s[15:0];
			s = (seed + kbkx_pkg::ADD_ONE) * mix_a[7:0] + (mix_a >> 8);
			mix_a = s[23:0];
			s = (seed + kbkx_pkg::ADD_TWO) * mix_b[7:0] + (mix_b >> 8);
			mix_b = s[23:0];
			seed = {8'd0, mix_b[7:0]};
			key_pos++;
			if (key_pos >= key_cnt)
				key_pos = 0;
			r.byte_out = it.byte_in ^ seed[7:0];
			r.no_key = 1'b0;
		end
		cipher_bytes.push_back(r);
	endfunction

	task automatic send_beat(input logic act, input logic [7:0] b, input logic last);
		kbkx_pkg::in_t it;
		it.action = act;
		it.byte_in = b;
		it.key_last = last;
		@(negedge clk);
		if (jitter && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		encrypt_beat(it);
	endtask

	// drop valid and wait for every predicted beat to come back
	task automatic hold_off();
		@(negedge clk);
		item_valid <= 1'b0;
		while (cipher_bytes.size() != 0) @(posedge clk);
	endtask

	task automatic test_no_key();
		send_beat(kbkx_pkg::ACT_DATA, 8'h00, 1'b0);
		send_beat(kbkx_pkg::ACT_DATA, 8'hFF, 1'b1);
	endtask

	task automatic test_partial_key();
		send_beat(kbkx_pkg::ACT_KEY, 8'hA5, 1'b0);
		send_beat(kbkx_pkg::ACT_DATA, 8'h3C, 1'b0);
		send_beat(kbkx_pkg::ACT_KEY, 8'h00, 1'b1);
		send_beat(kbkx_pkg::ACT_DATA, 8'h00, 1'b0);
		send_beat(kbkx_pkg::ACT_DATA, 8'hFF, 1'b1);
		send_beat(kbkx_pkg::ACT_DATA, 8'h5A, 1'b0);
	endtask

	task automatic test_single_key();
		send_beat(kbkx_pkg::ACT_KEY, 8'hFF, 1'b1);
		send_beat(kbkx_pkg::ACT_DATA, 8'h81, 1'b0);
		send_beat(kbkx_pkg::ACT_DATA, 8'h7E, 1'b0);
		send_beat(kbkx_pkg::ACT_DATA, 8'h00, 1'b1);
		send_beat(kbkx_pkg::ACT_DATA, 8'hFF, 1'b0);
	endtask

	task automatic test_rekey();
		send_beat(kbkx_pkg::ACT_KEY, 8'h01, 1'b0);
		send_beat(kbkx_pkg::ACT_KEY, 8'h80, 1'b0);
		send_beat(kbkx_pkg::ACT_KEY, 8'h7F, 1'b1);
		send_beat(kbkx_pkg::ACT_DATA, 8'h55, 1'b0);
		send_beat(kbkx_pkg::ACT_DATA, 8'hAA, 1'b0);
		send_beat(kbkx_pkg::ACT_DATA, 8'h0F, 1'b1);
		hold_off();
	endtask

	task automatic test_random();
		int base;
		int done;
		int len;
		int pick;
		int next_drain;
		logic finish_key;
		base = n_counted;
		next_drain = 400;
		while (n_counted - base < RANDOM_ITEMS) begin
			done = n_counted - base;
			jitter = (done < RANDOM_ITEMS - 300) && ((done / 150) % 2 == 0);
			if (done >= next_drain) begin
				hold_off();
				next_drain += 400;
			end
			pick = $urandom_range(0, 9);
			if (pick < 7)
				len = $urandom_range(1, 8);
			else if (pick < 9)
				len = $urandom_range(9, kbkx_pkg::KEY_MAX);
			else
				len = $urandom_range(kbkx_pkg::KEY_MAX + 1, kbkx_pkg::KEY_MAX + 8);
			finish_key = ($urandom_range(0, 9) != 0);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 11) == 0)
					send_beat(kbkx_pkg::ACT_DATA, 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
				send_beat(kbkx_pkg::ACT_KEY, 8'($urandom_range(0, 255)),
					finish_key && i == len - 1);
			end
			len = $urandom_range(1, 24);
			for (int i = 0; i < len; i++)
				send_beat(kbkx_pkg::ACT_DATA, 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
		end
	endtask

	always begin
		@(negedge clk);
		if (jitter && $urandom_range(0, 5) == 0) begin
			result_stall <= 1'b1;
			repeat ($urandom_range(1, 15)) @(negedge clk);
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (cipher_bytes.size() == 0) begin
				report($sformatf("result %h/%b with nothing pending",
					result.byte_out, result.no_key));
			end else begin
				want = cipher_bytes.pop_front();
				n_checked++;
				if (result.byte_out !== want.byte_out)
					report($sformatf("byte_out got %h, predicted %h",
						result.byte_out, want.byte_out));
				if (result.no_key !== want.no_key)
					report($sformatf("no_key got %b, predicted %b",
						result.no_key, want.no_key));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t watchdog: no beat moved for %0d cycles", $time, QUIET_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_no_key();
		test_partial_key();
		test_single_key();
		test_rekey();
		test_random();
		hold_off();
		repeat (40) @(posedge clk);
		if (cipher_bytes.size() != 0)
			report($sformatf("%0d predicted beats never arrived", cipher_bytes.size()));
		$display("sent %0d key beats and %0d data beats, %0d of them before a key was armed",
			n_key, n_data, n_plain);
		$display("checked %0d result beats, %0d mismatches", n_checked, n_errors);
		if (n_errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+hdl
hdl/kbkx_pkg.sv
hdl/kbkx_ctrl.sv
hdl/kbkx_dp.sv
hdl/keyed_byte_keystream_xor.sv
dv/tb.sv
